[design/ismo_pkg.sv]
// ---------------------------------------------------------------------------
// IMU sample smoothing package
// Shared types and fixed constants for the smoothing block and its lanes.
// ---------------------------------------------------------------------------
`default_nettype none

package ismo_pkg;

	// Width of every sample and result field on the ports.
	localparam int FIELD_W = 16;

	// Width of the low-pass weight register and its full-scale value.
	localparam int WEIGHT_W = 17;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'd16384;

	// Control handed from the sequencer to every lane when a beat is taken.
	typedef struct packed {
		logic start;  // A new sample is presented this cycle.
		logic full;   // The ring slot being replaced holds a real sample.
		logic first;  // First sample since reset: load the filter state.
	} lane_ctrl_t;

endpackage

`default_nettype wire

[design/ismo_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered (old data on
// a same-address read and write).
// ---------------------------------------------------------------------------
`default_nettype none

module ismo_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[design/ismo_accel_lane.sv]
// ---------------------------------------------------------------------------
// Accelerometer moving-average lane
// Keeps the sample ring and running sum of one axis and divides the sum by
// the fill count with a one-bit-per-cycle restoring divider.
// ---------------------------------------------------------------------------
`default_nettype none

module ismo_accel_lane import ismo_pkg::*; #(
	parameter int W    = 16,
	parameter int SB   = 16,
	parameter int SUMW = SB + $clog2(W) + 1,
	parameter int CW   = $clog2(W + 1),
	parameter int PW   = (W > 1) ? $clog2(W) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lane_ctrl_t           ctrl,
	input  wire logic [PW-1:0]        pos,
	input  wire logic [CW-1:0]        count,
	input  wire logic signed [SB-1:0] sample,
	output logic                      done,
	output logic [FIELD_W-1:0]        result
);

	localparam int IW = $clog2(SUMW + 1);

	typedef enum logic [2:0] {
		A_IDLE = 3'b001,
		A_SUM  = 3'b010,
		A_DIV  = 3'b100
	} acc_state_t;

	acc_state_t             state_q;
	logic                   done_q;
	logic                   full_q;
	logic [CW-1:0]          div_q;
	logic signed [SB-1:0]   x_q;
	logic signed [SUMW-1:0] sum_q;
	logic [SUMW-1:0]        mag_q;
	logic [CW-1:0]          rem_q;
	logic                   neg_q;
	logic [IW-1:0]          iter_q;
	logic [SB-1:0]          old_raw;
	logic signed [SUMW-1:0] old_val;
	logic signed [SUMW-1:0] new_sum;
	logic [CW:0]            rem2;
	logic                   ge;
	logic signed [SUMW-1:0] quot;

	// Ring of past samples for this axis.
	ismo_ram #(
		.WIDTH(SB),
		.DEPTH(W)
	) u_ring (
		.clk   (clk),
		.we    (ctrl.start),
		.waddr (pos),
		.wdata (sample),
		.raddr (pos),
		.rdata (old_raw)
	);

	// Running-sum update: drop the replaced sample, add the new one.
	always_comb begin
		old_val = full_q ? SUMW'(signed'(old_raw)) : '0;
		new_sum = sum_q - old_val + SUMW'(x_q);
	end

	// One restoring division step.
	always_comb begin
		rem2 = {rem_q, mag_q[SUMW-1]};
		ge   = (rem2 >= {1'b0, div_q});
	end

	// Lane sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
			sum_q   <= '0;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (ctrl.start) begin
						done_q  <= 1'b0;
						state_q <= A_SUM;
					end
				end
				A_SUM: begin
					sum_q   <= new_sum;
					state_q <= A_DIV;
				end
				A_DIV: begin
					if (iter_q == IW'(SUMW - 1)) begin
						done_q  <= 1'b1;
						state_q <= A_IDLE;
					end
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == A_IDLE && ctrl.start) begin
			x_q    <= sample;
			full_q <= ctrl.full;
			div_q  <= count;
		end
		if (state_q == A_SUM) begin
			neg_q  <= new_sum[SUMW-1];
			mag_q  <= new_sum[SUMW-1] ? SUMW'(-new_sum) : SUMW'(new_sum);
			rem_q  <= '0;
			iter_q <= '0;
		end
		if (state_q == A_DIV) begin
			rem_q  <= ge ? CW'(rem2 - {1'b0, div_q}) : rem2[CW-1:0];
			mag_q  <= {mag_q[SUMW-2:0], ge};
			iter_q <= iter_q + 1'b1;
		end
	end

	// Quotient truncated toward zero.
	assign quot   = neg_q ? -signed'(mag_q) : signed'(mag_q);
	assign result = FIELD_W'(quot);
	assign done   = done_q;

endmodule

`default_nettype wire

[design/ismo_gyro_lane.sv]
// ---------------------------------------------------------------------------
// Gyro low-pass lane
// First-order filter with a Q16.16 state, updated as s + floor(a * (x - s))
// with the product split into two narrow multiplies.
// ---------------------------------------------------------------------------
`default_nettype none

module ismo_gyro_lane import ismo_pkg::*; #(
	parameter int SB = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lane_ctrl_t           ctrl,
	input  wire logic [WEIGHT_W-1:0]  weight,
	input  wire logic signed [SB-1:0] sample,
	output logic                      done,
	output logic [FIELD_W-1:0]        result
);

	localparam int SW = SB + 16;
	localparam int DW = SB + 17;
	localparam int PHW = SB + 19;

	typedef enum logic [2:0] {
		G_IDLE = 3'b001,
		G_MUL  = 3'b010,
		G_ADD  = 3'b100
	} gyro_state_t;

	gyro_state_t          state_q;
	logic                 done_q;
	logic signed [SW-1:0] s_q;
	logic signed [SB-1:0] x_q;
	logic [WEIGHT_W-1:0]  a_q;
	logic                 first_q;
	logic signed [DW-1:0] diff;
	logic [15:0]          diff_lo;
	logic signed [SB:0]   diff_hi;
	logic [32:0]          p_lo_s1;
	logic signed [PHW-1:0] p_hi_s1;
	logic signed [PHW-1:0] s_new;

	// Difference between the new sample in Q16.16 and the state.
	always_comb begin
		diff    = DW'(signed'({x_q, 16'h0000})) - DW'(s_q);
		diff_lo = diff[15:0];
		diff_hi = signed'(diff[DW-1:16]);
	end

	// State plus the floored weighted difference.
	assign s_new = PHW'(s_q) + p_hi_s1 + signed'(PHW'(p_lo_s1[32:16]));

	// Lane sequencer and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			done_q  <= 1'b0;
			s_q     <= '0;
		end else begin
			case (state_q)
				G_IDLE: begin
					if (ctrl.start) begin
						done_q  <= 1'b0;
						state_q <= G_MUL;
					end
				end
				G_MUL: begin
					if (first_q) begin
						s_q     <= signed'({x_q, 16'h0000});
						done_q  <= 1'b1;
						state_q <= G_IDLE;
					end else begin
						state_q <= G_ADD;
					end
				end
				G_ADD: begin
					s_q     <= s_new[SW-1:0];
					done_q  <= 1'b1;
					state_q <= G_IDLE;
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	// Sample capture and product registers.
	always_ff @(posedge clk) begin
		if (state_q == G_IDLE && ctrl.start) begin
			x_q     <= sample;
			a_q     <= weight;
			first_q <= ctrl.first;
		end
		if (state_q == G_MUL) begin
			p_lo_s1 <= a_q * diff_lo;
			p_hi_s1 <= signed'({1'b0, a_q}) * diff_hi;
		end
	end

	// Output is the floor of the state.
	assign result = FIELD_W'(signed'(s_q[SW-1:16]));
	assign done   = done_q;

endmodule

`default_nettype wire

[design/imu_sample_smoothing_top.sv]
// ---------------------------------------------------------------------------
// IMU sample smoothing top level
// Three accelerometer moving-average lanes and three gyro low-pass lanes
// run side by side; their results are merged into one output register.
// ---------------------------------------------------------------------------
//
//  Channel  Signals                        Direction  Carries
//  in       in_valid / in_ready            input      accel_x..z, gyro_x..z
//  out      out_valid / out_ready          output     smooth_accel_*, smooth_gyro_*
//  cfg      cfg_valid / cfg_ready          input      cfg_data (low-pass weight)
//
// The time one sample takes is set by the bit-serial divider in the
// accelerometer lanes. A new beat is taken once the previous result has
// moved to the output register; a stalled output holds only the next
// result in the lanes. Reset clears the window fill count, so ring entries
// never written read as zero without a clearing pass. Configuration
// writes are taken every cycle.
//
`default_nettype none

module imu_sample_smoothing_top import ismo_pkg::*; #(
	parameter int WINDOW_LEN  = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [FIELD_W-1:0]  accel_x,
	input  wire logic [FIELD_W-1:0]  accel_y,
	input  wire logic [FIELD_W-1:0]  accel_z,
	input  wire logic [FIELD_W-1:0]  gyro_x,
	input  wire logic [FIELD_W-1:0]  gyro_y,
	input  wire logic [FIELD_W-1:0]  gyro_z,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [FIELD_W-1:0]       smooth_accel_x,
	output logic [FIELD_W-1:0]       smooth_accel_y,
	output logic [FIELD_W-1:0]       smooth_accel_z,
	output logic [FIELD_W-1:0]       smooth_gyro_x,
	output logic [FIELD_W-1:0]       smooth_gyro_y,
	output logic [FIELD_W-1:0]       smooth_gyro_z,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [WEIGHT_W-1:0] cfg_data
);

	localparam int CW = $clog2(WINDOW_LEN + 1);
	localparam int PW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int SB = SAMPLE_BITS;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_HOLD = 3'b100
	} top_state_t;

	top_state_t           state_q;
	logic [WEIGHT_W-1:0]  weight_q;
	logic [PW-1:0]        pos_q;
	logic [CW-1:0]        count_q;
	logic                 first_q;
	logic                 out_valid_q;
	logic [FIELD_W-1:0]   res_q [6];
	logic                 in_fire;
	logic                 window_full;
	logic [CW-1:0]        count_next;
	logic [WEIGHT_W-1:0]  weight_sat;
	lane_ctrl_t           ctrl;
	logic [FIELD_W-1:0]   raw_in [6];
	logic [FIELD_W-1:0]   lane_res [6];
	logic [5:0]           lane_done;
	logic                 load_out;

	assign raw_in[0] = accel_x;
	assign raw_in[1] = accel_y;
	assign raw_in[2] = accel_z;
	assign raw_in[3] = gyro_x;
	assign raw_in[4] = gyro_y;
	assign raw_in[5] = gyro_z;

	// Handshakes and lane control.
	assign in_ready    = (state_q == ST_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign cfg_ready   = 1'b1;
	assign window_full = (count_q == CW'(WINDOW_LEN));
	assign count_next  = window_full ? count_q : count_q + 1'b1;
	assign weight_sat  = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
	assign load_out    = (state_q == ST_HOLD) && (!out_valid_q || out_ready);

	always_comb begin
		ctrl.start = in_fire;
		ctrl.full  = window_full;
		ctrl.first = first_q;
	end

	// Lanes, one per axis.
	for (genvar i = 0; i < 3; i++) begin : g_accel
		ismo_accel_lane #(
			.W  (WINDOW_LEN),
			.SB (SB),
			.CW (CW),
			.PW (PW)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.pos    (pos_q),
			.count  (count_next),
			.sample (signed'(SB'(raw_in[i]))),
			.done   (lane_done[i]),
			.result (lane_res[i])
		);
	end

	for (genvar i = 0; i < 3; i++) begin : g_gyro
		ismo_gyro_lane #(
			.SB (SB)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.weight (weight_sat),
			.sample (signed'(SB'(raw_in[3 + i]))),
			.done   (lane_done[3 + i]),
			.result (lane_res[3 + i])
		);
	end

	// Sequencer, window bookkeeping and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			weight_q    <= WEIGHT_RST;
			pos_q       <= '0;
			count_q     <= '0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				weight_q <= cfg_data;
			end
			// Output beat: a new result replaces a taken or empty one.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						pos_q   <= (pos_q == PW'(WINDOW_LEN - 1)) ? '0 : pos_q + 1'b1;
						count_q <= count_next;
						first_q <= 1'b0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (&lane_done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Merge the lane results into the output register.
	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q <= lane_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign smooth_accel_x = res_q[0];
	assign smooth_accel_y = res_q[1];
	assign smooth_accel_z = res_q[2];
	assign smooth_gyro_x  = res_q[3];
	assign smooth_gyro_y  = res_q[4];
	assign smooth_gyro_z  = res_q[5];

endmodule

`default_nettype wire

[design/ismo_checker.sv]
// ---------------------------------------------------------------------------
// IMU sample smoothing port checker
// Watches the top-level ports for handshake and sequencing slips.
// ---------------------------------------------------------------------------
`default_nettype none

module ismo_checker import ismo_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [FIELD_W-1:0] smooth_accel_x,
	input wire logic [FIELD_W-1:0] smooth_gyro_x,
	input wire logic               cfg_ready
);

	// A waiting result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// A waiting result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(smooth_accel_x) && $stable(smooth_gyro_x))
		else $error("result payload changed while stalled");

	// One sample at a time: the input closes after a beat is taken.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a sample is in flight");

	// The lanes must finish before a result is loaded, so no result appears right after a beat.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// Configuration is always taken.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

endmodule

bind imu_sample_smoothing_top ismo_checker u_ismo_checker (.*);

`default_nettype wire

[test/tb.sv]
// ---------------------------------------------------------------------------
// IMU sample smoothing testbench
// Drives IMU samples through the smoothing block with random idling on both
// channels, predicts every result from its own model of the moving average
// and gyro low-pass filter, and compares each output beat in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb import ismo_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN = 16;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [FIELD_W-1:0] ax, ay, az, gx, gy, gz;
	} imu_beat_t;

	typedef struct {
		bit        is_cfg;
		imu_beat_t beat;
		logic [WEIGHT_W-1:0] weight;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
	logic in_ready, out_valid, cfg_ready;
	logic [FIELD_W-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic [FIELD_W-1:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
	logic [FIELD_W-1:0] smooth_accel_x, smooth_accel_y, smooth_accel_z;
	logic [FIELD_W-1:0] smooth_gyro_x, smooth_gyro_y, smooth_gyro_z;
	logic [WEIGHT_W-1:0] cfg_data = '0;

	imu_sample_smoothing_top #(.WINDOW_LEN(WIN), .SAMPLE_BITS(FIELD_W)) dut (.*);

	always #4 clk = ~clk;

	// Smoothing state mirrored by the predictor.
	longint ring [3][WIN];
	longint win_sum [3];
	int     ring_pos, fill_count;
	longint lp_state [3];
	bit     lp_started;
	longint lp_weight;

	pending_t  stim_q [$];
	imu_beat_t smoothed_q [$];
	int  mismatches = 0;
	int  idle_cycles = 0;
	bit  stim_done = 0;
	bit  calm = 0;
	int  beat_count = 0;

	function automatic longint floor_div16(longint v);
		return v >>> 16;
	endfunction

	// Advance the model by one sample and queue the expected output beat.
	function automatic void smooth_sample(imu_beat_t s);
		longint ain [3], gin [3];
		longint q, a;
		imu_beat_t r;
		ain = '{longint'($signed(s.ax)), longint'($signed(s.ay)), longint'($signed(s.az))};
		gin = '{longint'($signed(s.gx)), longint'($signed(s.gy)), longint'($signed(s.gz))};
		a = (lp_weight > 65536) ? 65536 : lp_weight;
		if (fill_count < WIN) fill_count++;
		for (int i = 0; i < 3; i++) begin
			win_sum[i] = win_sum[i] - ring[i][ring_pos] + ain[i];
			ring[i][ring_pos] = ain[i];
			q = win_sum[i] / fill_count;
			if (i == 0) r.ax = q[15:0];
			else if (i == 1) r.ay = q[15:0];
			else r.az = q[15:0];
		end
		ring_pos = (ring_pos + 1) % WIN;
		for (int i = 0; i < 3; i++) begin
			if (!lp_started) lp_state[i] = gin[i] <<< 16;
			else lp_state[i] = floor_div16(a * (gin[i] <<< 16) + (65536 - a) * lp_state[i]);
			q = floor_div16(lp_state[i]);
			if (i == 0) r.gx = q[15:0];
			else if (i == 1) r.gy = q[15:0];
			else r.gz = q[15:0];
		end
		lp_started = 1;
		smoothed_q.push_back(r);
	endfunction

	function automatic imu_beat_t rand_beat();
		imu_beat_t b;
		b = {$urandom, $urandom, $urandom};
		// Sometimes pin fields to their extremes.
		if ($urandom_range(0, 9) == 0) b.ax = 16'h8000;
		if ($urandom_range(0, 9) == 0) b.gy = 16'h7fff;
		if ($urandom_range(0, 9) == 0) b.gz = 16'h8000;
		return b;
	endfunction

	task automatic add_beat(imu_beat_t b);
		pending_t p;
		p.is_cfg = 0; p.beat = b; p.weight = '0;
		stim_q.push_back(p);
	endtask

	task automatic add_cfg(logic [WEIGHT_W-1:0] w);
		pending_t p;
		p.is_cfg = 1; p.beat = '0; p.weight = w;
		stim_q.push_back(p);
	endtask

	// Stimulus plan: directed extremes, then random phases over several weights.
	initial begin
		logic [WEIGHT_W-1:0] weights [6];
		weights = '{17'd0, 17'd65536, 17'd131071, 17'd1, 17'd40000, 17'd16384};
		for (int i = 0; i < 3; i++) add_beat({6{16'h7fff}});
		for (int i = 0; i < 3; i++) add_beat({6{16'h8000}});
		add_beat('0);
		add_beat({6{16'hffff}});
		add_beat({16'h7fff, 16'h8000, 16'h0001, 16'h8000, 16'h7fff, 16'hffff});
		for (int i = 0; i < 12; i++) add_beat(rand_beat());
		for (int k = 0; k < 6; k++) begin
			add_cfg(weights[k]);
			for (int i = 0; i < 100; i++) add_beat(rand_beat());
		end
		add_cfg(17'($urandom_range(0, 131071)));
		for (int i = 0; i < 20; i++) add_beat(rand_beat());
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: sample beats and configuration writes, with random idling.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				smooth_sample({accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z});
				beat_count++;
			end
			calm = (beat_count > 200 && beat_count < 320);
			if (cfg_valid && cfg_ready) lp_weight = cfg_data;
			if ((in_valid && !in_ready) || (cfg_valid && !cfg_ready)) begin
				// Hold the pending beat unchanged.
			end else if (stim_q.size() == 0) begin
				in_valid <= 1'b0;
				cfg_valid <= 1'b0;
				if (!(in_valid || cfg_valid)) stim_done = 1;
			end else if (stim_q[0].is_cfg) begin
				in_valid <= 1'b0;
				// Write the weight only once every result is back and the block is quiet.
				if (!cfg_valid && !in_valid && smoothed_q.size() == 0 && idle_cycles > 40) begin
					cfg_data <= stim_q[0].weight;
					cfg_valid <= 1'b1;
					void'(stim_q.pop_front());
				end else begin
					cfg_valid <= 1'b0;
				end
			end else if (!calm && $urandom_range(0, 99) < 9) begin
				in_valid <= 1'b0;
				cfg_valid <= 1'b0;
			end else begin
				cfg_valid <= 1'b0;
				{accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z} <= stim_q[0].beat;
				in_valid <= 1'b1;
				void'(stim_q.pop_front());
			end
		end
	end

	// Monitor: compare each output beat with the oldest prediction.
	always @(posedge clk) begin
		imu_beat_t got, want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = {smooth_accel_x, smooth_accel_y, smooth_accel_z,
					smooth_gyro_x, smooth_gyro_y, smooth_gyro_z};
				if (smoothed_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected output beat %h", got);
				end else begin
					want = smoothed_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected ax %h ay %h az %h gx %h gy %h gz %h, got ax %h ay %h az %h gx %h gy %h gz %h",
								want.ax, want.ay, want.az, want.gx, want.gy, want.gz,
								got.ax, got.ay, got.az, got.gx, got.gy, got.gz);
					end
				end
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 9);
		end
	end

	// Watchdog and end of run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (stim_done && smoothed_q.size() == 0 && idle_cycles > 60) begin
				if (mismatches == 0) $display("ALL CHECKS PASSED");
				else $display("CHECKS FAILED");
				$finish;
			end else if (idle_cycles > WATCHDOG) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		lp_weight = WEIGHT_RST;
		ring_pos = 0; fill_count = 0; lp_started = 0;
		foreach (win_sum[i]) win_sum[i] = 0;
		foreach (lp_state[i]) lp_state[i] = 0;
		foreach (ring[i, j]) ring[i][j] = 0;
	end

endmodule

`default_nettype wire
